>>> rtl/core/time_window_task_scheduler_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the time window task scheduler
// Concurrent checks that are dropped when the code is synthesised.
// ---------------------------------------------------------------------------
`ifndef TIME_WINDOW_TASK_SCHEDULER_ASSERT_SVH
`define TIME_WINDOW_TASK_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
`define TWS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TWS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWS_ASSERT(label, clk, rst_n, prop, msg)
`define TWS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/core/tws_pkg.sv
// ---------------------------------------------------------------------------
// Time window task scheduler package
// Types, status codes and defaults shared by the scheduler RTL.
// ---------------------------------------------------------------------------
package tws_pkg;

  localparam int unsigned DefMaxEntries = 10;
  localparam logic [15:0] DefTickStep   = 16'd1000;

  localparam logic [1:0] FuncAdd    = 2'd0;
  localparam logic [1:0] FuncRemove = 2'd1;
  localparam logic [1:0] FuncTick   = 2'd2;
  localparam logic [1:0] FuncNone   = 2'd3;

  localparam logic [2:0] StAdded    = 3'd0;
  localparam logic [2:0] StRejected = 3'd1;
  localparam logic [2:0] StRemoved  = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFired    = 3'd4;
  localparam logic [2:0] StNoneFire = 3'd5;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] period;
    logic [31:0] wstart;
    logic [31:0] wend;
    logic [31:0] countdown;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT,
    S_R_RD,
    S_R_CHK,
    S_R_SH,
    S_R_SW,
    S_T_RD,
    S_T_CHK,
    S_T_MOD,
    S_T_UPD,
    S_T_END
  } state_e;

endpackage

>>> rtl/core/time_window_task_scheduler.sv
// ---------------------------------------------------------------------------
// Time window task scheduler
// Table of periodic tasks with active windows, held in a single memory.
// ---------------------------------------------------------------------------
// One request is worked on at a time. An add is checked and written in S_IDLE,
// and ignored requests are dropped; a remove reads and checks each entry in
// turn, then moves each later entry down one row. A tick reads and checks each
// table entry, and for each entry whose countdown is zero runs the bit-serial
// modulo unit that finds the phase within the period; it then ends in S_T_END.
// The table is a one-port-write, registered-read memory of MAX_ENTRIES rows.
`include "time_window_task_scheduler_assert.svh"

module time_window_task_scheduler
  import tws_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DefMaxEntries
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,       // tick_step_us
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] func, [9:2] task_id, [41:10] period_us,
  // [73:42] window_start_us, [105:74] window_end_us, [111:106] zero
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] status, [10:3] fired_id, [15:11] zero
  output logic [15:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTRIES);

  entry_t mem [MAX_ENTRIES];
  entry_t rdata_q;
  logic [AddrW-1:0] raddr;
  logic             we;
  logic [AddrW-1:0] waddr;
  entry_t           wdata;

  state_e state_q, state_d;
  logic [15:0] step_q;
  logic [CntW-1:0] count_q, count_d, idx_q, idx_d;
  logic [31:0] gtime_q, gtime_d;
  entry_t ent_q, ent_d;
  logic [31:0] rem_q, rem_d, dvd_q, dvd_d;
  logic [4:0]  bit_q, bit_d;
  logic        fire_q, fire_d;
  logic        pend_q, pend_d;
  logic [7:0]  pid_q, pid_d;
  logic [2:0]  rst_q, rst_d;
  logic [7:0]  rid_q, rid_d;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [7:0]  out_id_q;
  logic        out_last_q;
  logic        emit, slot;
  logic [2:0]  e_status;
  logic [7:0]  e_id;
  logic        e_last;

  logic [1:0]  in_func;
  logic [7:0]  in_id;
  logic [31:0] in_period, in_start, in_end;
  logic [32:0] trial;
  logic [32:0] trial_sub;
  logic [31:0] cd_next;

  assign in_func   = s_axis_tdata[1:0];
  assign in_id     = s_axis_tdata[9:2];
  assign in_period = s_axis_tdata[41:10];
  assign in_start  = s_axis_tdata[73:42];
  assign in_end    = s_axis_tdata[105:74];

  assign slot = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  assign trial     = {rem_q, dvd_q[31]};
  assign trial_sub = trial - {1'b0, ent_q.period};
  assign cd_next   = (ent_q.countdown > {16'd0, step_q}) ?
                     (ent_q.countdown - {16'd0, step_q}) : 32'd0;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    gtime_d  = gtime_q;
    ent_d    = ent_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    bit_d    = bit_q;
    fire_d   = fire_q;
    pend_d   = pend_q;
    pid_d    = pid_q;
    rst_d    = rst_q;
    rid_d    = rid_q;
    raddr    = idx_q[AddrW-1:0];
    we       = 1'b0;
    waddr    = idx_q[AddrW-1:0];
    wdata    = ent_q;
    emit     = 1'b0;
    e_status = rst_q;
    e_id     = rid_q;
    e_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          rid_d = in_id;
          idx_d = '0;
          unique case (in_func)
            FuncAdd: begin
              state_d = S_EMIT;
              if (in_period == 32'd0 || in_end <= in_start || count_q >= MaxCnt) begin
                rst_d = StRejected;
              end else begin
                rst_d = StAdded;
                we    = 1'b1;
                waddr = count_q[AddrW-1:0];
                wdata = '{id: in_id, period: in_period, wstart: in_start,
                          wend: in_end, countdown: 32'd0};
                count_d = count_q + 1'b1;
              end
            end
            FuncRemove: state_d = S_R_RD;
            FuncTick: begin
              pend_d  = 1'b0;
              state_d = (count_q == '0) ? S_T_END : S_T_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        if (slot) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_R_RD: begin
        if (idx_q == count_q) begin
          rst_d   = StNotFound;
          state_d = S_EMIT;
        end else begin
          state_d = S_R_CHK;
        end
      end
      S_R_CHK: begin
        if (rdata_q.id == rid_q) begin
          state_d = S_R_SH;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_R_RD;
        end
      end
      S_R_SH: begin
        if (idx_q + 1'b1 == count_q) begin
          count_d = count_q - 1'b1;
          rst_d   = StRemoved;
          state_d = S_EMIT;
        end else begin
          raddr   = AddrW'(idx_q + 1'b1);
          state_d = S_R_SW;
        end
      end
      S_R_SW: begin
        we      = 1'b1;
        wdata   = rdata_q;
        idx_d   = idx_q + 1'b1;
        state_d = S_R_SH;
      end
      S_T_RD: state_d = S_T_CHK;
      S_T_CHK: begin
        ent_d  = rdata_q;
        fire_d = 1'b0;
        if (rdata_q.countdown == 32'd0) begin
          rem_d   = 32'd0;
          dvd_d   = gtime_q;
          bit_d   = 5'd31;
          state_d = S_T_MOD;
        end else begin
          state_d = S_T_UPD;
        end
      end
      S_T_MOD: begin
        if (trial_sub[32]) begin
          rem_d = trial[31:0];
        end else begin
          rem_d = trial_sub[31:0];
        end
        dvd_d = {dvd_q[30:0], 1'b0};
        bit_d = bit_q - 1'b1;
        if (bit_q == 5'd0) begin
          fire_d          = (rem_d >= ent_q.wstart) && (rem_d < ent_q.wend);
          ent_d.countdown = ent_q.period;
          state_d         = S_T_UPD;
        end
      end
      S_T_UPD: begin
        if (!(fire_q && pend_q) || slot) begin
          if (fire_q) begin
            if (pend_q) begin
              emit     = 1'b1;
              e_status = StFired;
              e_id     = pid_q;
              e_last   = 1'b0;
            end
            pend_d = 1'b1;
            pid_d  = ent_q.id;
          end
          we              = 1'b1;
          wdata           = ent_q;
          wdata.countdown = cd_next;
          idx_d           = idx_q + 1'b1;
          state_d         = (idx_q + 1'b1 == count_q) ? S_T_END : S_T_RD;
        end
      end
      S_T_END: begin
        if (slot) begin
          emit     = 1'b1;
          e_status = pend_q ? StFired : StNoneFire;
          e_id     = pend_q ? pid_q : 8'd0;
          gtime_d  = gtime_q + {16'd0, step_q};
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= DefTickStep;
      count_q     <= '0;
      gtime_q     <= 32'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      gtime_q <= gtime_d;
      pend_q  <= pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    ent_q  <= ent_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    bit_q  <= bit_d;
    fire_q <= fire_d;
    pid_q  <= pid_d;
    rst_q  <= rst_d;
    rid_q  <= rid_d;
    if (emit) begin
      out_status_q <= e_status;
      out_id_q     <= e_id;
      out_last_q   <= e_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_id_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

  `TWS_ASSERT(a_count_max, clk_i, rst_ni, count_q <= MaxCnt, "entry count exceeds table size")
  `TWS_ASSERT(a_emit_slot, clk_i, rst_ni, emit |-> slot, "result overwrites an unread result")
  `TWS_ASSERT(a_none_last, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[2:0] == StNoneFire) |-> m_axis_tlast, "idle tick result without last")
  `TWS_ASSERT(a_busy_after, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != FuncNone) |=> !s_axis_tready, "new request taken while busy")

endmodule

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// Time window task scheduler testbench
// Drives add, remove, tick and no-op requests with random stalls on both streams,
// predicts the result stream from a behavioural copy of the task table and
// compares every result field by field.
// ---------------------------------------------------------------------------
module tb_top;
  import tws_pkg::*;

  localparam int unsigned NumEntries = DefMaxEntries;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [15:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;
  logic         m_axis_tlast;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] id;
    logic       last;
  } result_t;

  entry_t      table_q [NumEntries];
  int unsigned entry_cnt;
  logic [31:0] now_us;
  logic [15:0] step_us;
  result_t     pending_q [$];
  int          errors;
  bit          calm;
  int          stall_cnt;

  time_window_task_scheduler u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic schedule_predict(input logic [1:0] fn, input logic [7:0] id,
                                  input logic [31:0] per, input logic [31:0] ws,
                                  input logic [31:0] we);
    int fired;
    logic [31:0] phase;
    fired = 0;
    if (fn == FuncAdd) begin
      if (per == 0 || we <= ws || entry_cnt >= NumEntries) begin
        pending_q.push_back('{StRejected, id, 1'b1});
      end else begin
        table_q[entry_cnt] = '{id, per, ws, we, 32'd0};
        entry_cnt++;
        pending_q.push_back('{StAdded, id, 1'b1});
      end
    end else if (fn == FuncRemove) begin
      for (int i = 0; i < entry_cnt; i++) begin
        if (table_q[i].id == id) begin
          for (int j = i; j + 1 < entry_cnt; j++) table_q[j] = table_q[j+1];
          entry_cnt--;
          fired = 1;
          break;
        end
      end
      pending_q.push_back('{fired ? StRemoved : StNotFound, id, 1'b1});
    end else if (fn == FuncTick) begin
      for (int i = 0; i < entry_cnt; i++) begin
        if (table_q[i].countdown == 0) begin
          phase = now_us % table_q[i].period;
          if (phase >= table_q[i].wstart && phase < table_q[i].wend) begin
            pending_q.push_back('{StFired, table_q[i].id, 1'b0});
            fired++;
          end
          table_q[i].countdown = table_q[i].period;
        end
        if (table_q[i].countdown > step_us) table_q[i].countdown -= step_us;
        else table_q[i].countdown = 0;
      end
      now_us += step_us;
      if (fired == 0) pending_q.push_back('{StNoneFire, 8'd0, 1'b1});
      else pending_q[$].last = 1'b1;
    end
  endtask

  task automatic send_request(input logic [1:0] fn, input logic [7:0] id,
                              input logic [31:0] per, input logic [31:0] ws,
                              input logic [31:0] we);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, we, ws, per, id, fn};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    schedule_predict(fn, id, per, ws, we);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  task automatic set_step(input logic [15:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    step_us = v;
  endtask

  task automatic clear_table();
    while (entry_cnt != 0) send_request(FuncRemove, table_q[0].id, 0, 0, 0);
  endtask

  task automatic test_directed();
    send_request(FuncTick, 8'd0, 0, 0, 0);
    send_request(FuncRemove, 8'hff, 0, 0, 0);
    send_request(FuncAdd, 8'd1, 0, 0, 10);
    send_request(FuncAdd, 8'd2, 100, 50, 50);
    send_request(FuncAdd, 8'd3, 100, 60, 40);
    send_request(FuncAdd, 8'hff, 32'hffff_ffff, 0, 32'hffff_ffff);
    send_request(FuncAdd, 8'd0, 3000, 0, 1000);
    send_request(FuncAdd, 8'd7, 1, 0, 1);
    send_request(FuncAdd, 8'd7, 2500, 2000, 2500);
    send_request(FuncAdd, 8'd9, 32'hffff_ffff, 32'hffff_fffe, 32'hffff_ffff);
    send_request(FuncTick, 8'd0, 0, 0, 0);
    send_request(FuncTick, 8'd0, 0, 0, 0);
    send_request(FuncRemove, 8'd7, 0, 0, 0);
    send_request(FuncNone, 8'haa, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff);
    for (int i = 0; i < 8; i++) send_request(FuncAdd, 8'(20 + i), 500, 0, 250);
    send_request(FuncTick, 8'd0, 0, 0, 0);
    send_request(FuncTick, 8'd0, 0, 0, 0);
    clear_table();
  endtask

  task automatic test_step_extremes();
    set_step(16'hffff);
    send_request(FuncAdd, 8'd5, 70000, 0, 40000);
    send_request(FuncAdd, 8'd6, 100, 0, 100);
    repeat (4) send_request(FuncTick, 8'd0, 0, 0, 0);
    set_step(16'd0);
    repeat (3) send_request(FuncTick, 8'd0, 0, 0, 0);
    set_step(16'd1);
    repeat (4) send_request(FuncTick, 8'd0, 0, 0, 0);
    clear_table();
  endtask

  task automatic test_random(input int n);
    logic [31:0] per, ws, we;
    logic [7:0]  id;
    int          k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      id = (k < 50) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        per = $urandom; ws = $urandom; we = $urandom;
      end else begin
        per = $urandom_range(1, 8000);
        ws  = $urandom_range(0, per - 1);
        we  = $urandom_range(ws + 1, per + 100);
      end
      if (k < 35) send_request(FuncAdd, id, per, ws, we);
      else if (k < 50) send_request(FuncRemove, id, 0, 0, 0);
      else if (k < 97) send_request(FuncTick, 8'd0, 0, 0, 0);
      else send_request(FuncNone, id, per, ws, we);
      if (i == n / 2) drain_results();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_q.size() == 0) begin
          $error("unexpected result status=%0d id=%0d", m_axis_tdata[2:0],
                 m_axis_tdata[10:3]);
          errors++;
        end else begin
          if (m_axis_tdata[2:0] != pending_q[0].status) begin
            $error("status expected %0d actual %0d", pending_q[0].status,
                   m_axis_tdata[2:0]);
            errors++;
          end
          if (m_axis_tdata[10:3] != pending_q[0].id) begin
            $error("fired_id expected %0d actual %0d", pending_q[0].id,
                   m_axis_tdata[10:3]);
            errors++;
          end
          if (m_axis_tlast != pending_q[0].last) begin
            $error("last expected %0d actual %0d", pending_q[0].last, m_axis_tlast);
            errors++;
          end
          void'(pending_q.pop_front());
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_cnt <= $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
      if (idle > 20000) begin
        $display("FAIL time_window_task_scheduler");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    errors = 0;
    calm = 0;
    stall_cnt = 0;
    entry_cnt = 0;
    now_us = '0;
    step_us = DefTickStep;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_step_extremes();
    set_step(16'd1000);
    test_random(120);
    set_step(16'($urandom_range(1, 4000)));
    calm = 1;
    test_random(30);
    drain_results();
    if (errors == 0) $display("PASS time_window_task_scheduler");
    else $display("FAIL time_window_task_scheduler");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tws_pkg.sv
rtl/core/time_window_task_scheduler.sv
dv/tb_top.sv
